[hdl/spg_pkg.sv]
// spg_pkg: shared types, constants and helper functions of the spiral point generator
// used by spg_divider, spg_cordic, spg_scale and spiral_point_generator_core
// no dependencies
package spg_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_OUTER_RADIUS    = 2'd0;
  localparam logic [1:0] REG_BAR_HEIGHT      = 2'd1;
  localparam logic [1:0] REG_RING_GAP        = 2'd2;
  localparam logic [1:0] REG_POINTS_PER_TURN = 2'd3;

  localparam int LEN_W  = 31;  // radius, bar height, ring gap
  localparam int PPT_W  = 16;  // points per turn
  localparam int IDX_W  = 16;  // point index
  localparam int COORD_W = 32;

  // pipelined long division, four quotient bits per stage
  localparam int DIV_W      = 52;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEP;

  // radius is signed and well below 2^50 in magnitude
  localparam int RAD_W = 52;

  // cordic datapath, Q2.30 unit values and phase of 2^32 per turn
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int MAX_STAGES = 24;

  typedef struct packed {
    logic [DIV_STEP-1:0] q;
    logic [PPT_W-1:0]    r;
  } spg_divstep_t;

  // values carried alongside the cordic rotation
  typedef struct packed {
    logic signed [RAD_W-1:0] radius;
    logic [1:0]              quad;
  } spg_side_t;

  // four restoring division steps; remainder stays below the divisor
  function automatic spg_divstep_t div_step(input logic [PPT_W-1:0] r_in,
                                            input logic [DIV_STEP-1:0] bits,
                                            input logic [PPT_W-1:0] d);
    spg_divstep_t res;
    logic [PPT_W:0] t;
    logic [PPT_W-1:0] r;
    r = r_in;
    res.q = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        r = PPT_W'(t - {1'b0, d});
        res.q[i] = 1'b1;
      end else begin
        r = t[PPT_W-1:0];
        res.q[i] = 1'b0;
      end
    end
    res.r = r;
    return res;
  endfunction

  // arctangent of 2^-k in phase units (2^32 per turn)
  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] k);
    logic signed [CW-1:0] a;
    unique case (k)
      5'd0:  a = 34'sd536870912;
      5'd1:  a = 34'sd316933406;
      5'd2:  a = 34'sd167458907;
      5'd3:  a = 34'sd85004756;
      5'd4:  a = 34'sd42667331;
      5'd5:  a = 34'sd21354465;
      5'd6:  a = 34'sd10679838;
      5'd7:  a = 34'sd5340245;
      5'd8:  a = 34'sd2670163;
      5'd9:  a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[hdl/spg_divider.sv]
// spg_divider: pipelined unsigned long division of a 52-bit dividend by a 16-bit divisor
// four quotient bits per stage, valid bits travel with the data
// depends on spg_pkg
module spg_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [spg_pkg::DIV_W-1:0]   dividend,
  input  logic [spg_pkg::PPT_W-1:0]   divisor,
  output logic                        out_valid,
  output logic [spg_pkg::DIV_W-1:0]   quotient
);

  // each word holds quotient bits above and untouched dividend bits below
  logic [spg_pkg::DIV_W-1:0] w [spg_pkg::DIV_STAGES+1];
  logic [spg_pkg::PPT_W-1:0] r [spg_pkg::DIV_STAGES+1];
  logic                      v [spg_pkg::DIV_STAGES+1];

  assign w[0] = dividend;
  assign r[0] = '0;
  assign v[0] = in_valid;

  for (genvar i = 0; i < spg_pkg::DIV_STAGES; i++) begin : g_stage
    localparam int TOP = spg_pkg::DIV_W - 1 - spg_pkg::DIV_STEP * i;
    spg_pkg::spg_divstep_t st;
    logic [spg_pkg::DIV_W-1:0] w_next;

    // four division steps on the next dividend bits
    always_comb begin
      st = spg_pkg::div_step(r[i], w[i][TOP -: spg_pkg::DIV_STEP], divisor);
      w_next = w[i];
      w_next[TOP -: spg_pkg::DIV_STEP] = st.q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w[i+1] <= w_next;
        r[i+1] <= st.r;
      end
    end
  end

  assign out_valid = v[spg_pkg::DIV_STAGES];
  assign quotient  = w[spg_pkg::DIV_STAGES];

endmodule

[hdl/spg_cordic.sv]
// spg_cordic: rotation-mode cordic pipeline, one micro-rotation per stage
// carries radius and quadrant alongside; depends on spg_pkg
module spg_cordic #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [spg_pkg::CW-1:0] phase,
  input  spg_pkg::spg_side_t            side_in,
  output logic                          out_valid,
  output logic signed [spg_pkg::CW-1:0] cos_out,
  output logic signed [spg_pkg::CW-1:0] sin_out,
  output spg_pkg::spg_side_t            side_out
);

  logic signed [spg_pkg::CW-1:0] x [STAGES+1];
  logic signed [spg_pkg::CW-1:0] y [STAGES+1];
  logic signed [spg_pkg::CW-1:0] z [STAGES+1];
  spg_pkg::spg_side_t            sd [STAGES+1];
  logic                          v [STAGES+1];

  assign x[0]  = spg_pkg::CORDIC_GAIN;
  assign y[0]  = '0;
  assign z[0]  = phase;
  assign sd[0] = side_in;
  assign v[0]  = in_valid;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [spg_pkg::CW-1:0] dx;
    logic signed [spg_pkg::CW-1:0] dy;
    logic signed [spg_pkg::CW-1:0] at;

    // floor shifts and the arctangent of this stage
    always_comb begin
      dx = y[k] >>> k;
      dy = x[k] >>> k;
      at = spg_pkg::atan_turn(5'(k));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    // rotate toward zero residual phase
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        if (!z[k][spg_pkg::CW-1]) begin
          x[k+1] <= x[k] - dx;
          y[k+1] <= y[k] + dy;
          z[k+1] <= z[k] - at;
        end else begin
          x[k+1] <= x[k] + dx;
          y[k+1] <= y[k] - dy;
          z[k+1] <= z[k] + at;
        end
      end
    end
  end

  assign out_valid = v[STAGES];
  assign cos_out   = x[STAGES];
  assign sin_out   = y[STAGES];
  assign side_out  = sd[STAGES];

endmodule

[hdl/spg_scale.sv]
// spg_scale: radius times Q30 unit value, truncated toward zero and saturated to 32 bits
// four stages: magnitudes, split multiply, combine, sign and clamp; depends on spg_pkg
module spg_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [spg_pkg::RAD_W-1:0] radius,
  input  logic signed [spg_pkg::CW-1:0]    unit,
  output logic                             out_valid,
  output logic signed [spg_pkg::COORD_W-1:0] coord
);

  logic [3:0] v;

  // stage 1: magnitudes and result sign
  logic [50:0] rm;
  logic [31:0] cm;
  logic        neg1;
  // stage 2: partial products
  logic [53:0] hi;
  logic [60:0] lo;
  logic        neg2;
  // stage 3: combined magnitude
  logic [32:0] mag;
  logic        neg3;

  logic [spg_pkg::RAD_W-1:0] r_abs;
  logic [spg_pkg::CW-1:0]    c_abs;
  logic [62:0]               sum;
  logic [32:0]               mag_next;
  logic [32:0]               lim;
  logic [spg_pkg::COORD_W-1:0] coord_next;

  always_comb begin
    r_abs = radius[spg_pkg::RAD_W-1] ? spg_pkg::RAD_W'(-radius) : radius;
    c_abs = unit[spg_pkg::CW-1] ? spg_pkg::CW'(-unit) : unit;
  end

  // combine partial products, any high overflow saturates
  always_comb begin
    sum = {hi[32:0], 29'b0} + {2'b0, lo};
    if (|hi[53:33]) begin
      mag_next = 33'h1_0000_0000;
    end else begin
      mag_next = sum[62:30];
    end
  end

  // clamp to the signed range and apply the sign
  always_comb begin
    if (neg3) begin
      lim = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
      coord_next = 32'(~lim + 33'd1);
    end else begin
      lim = (mag > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : mag;
      coord_next = lim[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm    <= r_abs[50:0];
      cm    <= c_abs[31:0];
      neg1  <= radius[spg_pkg::RAD_W-1] ^ unit[spg_pkg::CW-1];
      hi    <= rm[50:29] * cm;
      lo    <= rm[28:0] * cm;
      neg2  <= neg1;
      mag   <= mag_next;
      neg3  <= neg2;
      coord <= coord_next;
    end
  end

  assign out_valid = v[3];

endmodule

[hdl/spiral_point_generator_core.sv]
// spiral_point_generator_core: point index to X/Z coordinates on an inward spiral
// depends on spg_pkg, spg_divider, spg_cordic, spg_scale
//
//   port group   dir   handshake                 payload
//   input        in    in_valid / in_ready       point_index
//   result       out   out_valid / out_ready     coord_x, coord_z
//   config       in    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one point per cycle while the skid register is empty; the path runs through the
// 13-stage divider, one cordic stage per micro-rotation and the four-stage scaler
// reset restores the register defaults and empties the pipeline
// the whole pipeline advances together; a skid register at the output
// absorbs one result so in_ready drops only when output and skid are both full
module spiral_point_generator_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spg_pkg::IDX_W-1:0]           point_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [spg_pkg::COORD_W-1:0]  coord_x,
  output logic signed [spg_pkg::COORD_W-1:0]  coord_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [31:0]                         cfg_data
);

  // configuration registers
  logic [spg_pkg::LEN_W-1:0] outer_radius;
  logic [spg_pkg::LEN_W-1:0] bar_height;
  logic [spg_pkg::LEN_W-1:0] ring_gap;
  logic [spg_pkg::PPT_W-1:0] points_per_turn;

  logic [spg_pkg::PPT_W-1:0] ppt;
  logic [32:0]               pitch;
  logic                      en;

  // input and multiply stages
  logic                      a_v;
  logic [spg_pkg::IDX_W-1:0] a_idx;
  logic                      b_v;
  logic [spg_pkg::IDX_W-1:0] b_idx;
  logic [48:0]               b_prod;
  logic [48:0]               prod_next;

  // divider outputs
  logic                      d1_v;
  logic                      d2_v;
  logic [spg_pkg::DIV_W-1:0] q_off;
  logic [spg_pkg::DIV_W-1:0] q_turn;

  // angle prep stage
  logic                              c_v;
  logic signed [spg_pkg::CW-1:0]     c_z;
  spg_pkg::spg_side_t                c_side;
  logic signed [spg_pkg::RAD_W-1:0]  radius_next;
  logic [spg_pkg::CW-1:0]            turn_ext;
  logic [spg_pkg::CW-1:0]            turn_round;
  logic [2:0]                        qfull;
  logic signed [spg_pkg::CW-1:0]     z_next;

  // cordic outputs and rotation stage
  logic                              k_v;
  logic signed [spg_pkg::CW-1:0]     k_cos;
  logic signed [spg_pkg::CW-1:0]     k_sin;
  spg_pkg::spg_side_t                k_side;
  logic                              r_v;
  logic signed [spg_pkg::CW-1:0]     r_c;
  logic signed [spg_pkg::CW-1:0]     r_s;
  logic signed [spg_pkg::RAD_W-1:0]  r_radius;
  logic signed [spg_pkg::CW-1:0]     c_rot;
  logic signed [spg_pkg::CW-1:0]     s_rot;

  // scaler outputs
  logic                                 lx_v;
  logic                                 lz_v;
  logic signed [spg_pkg::COORD_W-1:0]   lx;
  logic signed [spg_pkg::COORD_W-1:0]   lz;
  logic                                 l_take;

  // skid register
  logic                                 s_v;
  logic signed [spg_pkg::COORD_W-1:0]   s_x;
  logic signed [spg_pkg::COORD_W-1:0]   s_z;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_radius    <= 31'd6553600;
      bar_height      <= 31'd655360;
      ring_gap        <= 31'd65536;
      points_per_turn <= 16'd360;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spg_pkg::REG_OUTER_RADIUS:    outer_radius    <= cfg_data[spg_pkg::LEN_W-1:0];
        spg_pkg::REG_BAR_HEIGHT:      bar_height      <= cfg_data[spg_pkg::LEN_W-1:0];
        spg_pkg::REG_RING_GAP:        ring_gap        <= cfg_data[spg_pkg::LEN_W-1:0];
        spg_pkg::REG_POINTS_PER_TURN: points_per_turn <= cfg_data[spg_pkg::PPT_W-1:0];
      endcase
    end
  end

  // derived settings, zero points per turn acts as one
  always_comb begin
    ppt   = (points_per_turn == '0) ? spg_pkg::PPT_W'(1) : points_per_turn;
    pitch = {1'b0, bar_height, 1'b0} + {2'b0, ring_gap};
  end

  assign en       = !s_v;
  assign in_ready = en;

  // input and multiply stages
  assign prod_next = a_idx * pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx  <= point_index;
      b_idx  <= a_idx;
      b_prod <= prod_next;
    end
  end

  // radial offset: index times pitch over points per turn
  spg_divider u_div_off (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_v),
    .dividend  ({3'b0, b_prod}),
    .divisor   (ppt),
    .out_valid (d1_v),
    .quotient  (q_off)
  );

  // phase: low 32 quotient bits of index * 2^32 over points per turn
  spg_divider u_div_turn (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_v),
    .dividend  ({4'b0, b_idx, 32'b0}),
    .divisor   (ppt),
    .out_valid (d2_v),
    .quotient  (q_turn)
  );

  // radius and quadrant split of the phase
  always_comb begin
    radius_next = $signed({21'b0, outer_radius}) - $signed({21'b0, bar_height})
                - $signed({3'b0, q_off[48:0]});
    turn_ext    = {2'b0, q_turn[31:0]};
    turn_round  = turn_ext + (spg_pkg::CW'(1) << 29);
    qfull       = turn_round[32:30];
    z_next      = $signed(turn_ext) - $signed({1'b0, qfull, 30'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= d1_v & d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_z           <= z_next;
      c_side.radius <= radius_next;
      c_side.quad   <= qfull[1:0];
    end
  end

  spg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .phase     (c_z),
    .side_in   (c_side),
    .out_valid (k_v),
    .cos_out   (k_cos),
    .sin_out   (k_sin),
    .side_out  (k_side)
  );

  // quadrant rotation
  always_comb begin
    unique case (k_side.quad)
      2'd0: begin c_rot = k_cos;  s_rot = k_sin;  end
      2'd1: begin c_rot = -k_sin; s_rot = k_cos;  end
      2'd2: begin c_rot = -k_cos; s_rot = -k_sin; end
      2'd3: begin c_rot = k_sin;  s_rot = -k_cos; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= k_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_c      <= c_rot;
      r_s      <= s_rot;
      r_radius <= k_side.radius;
    end
  end

  spg_scale u_scale_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_v),
    .radius    (r_radius),
    .unit      (r_c),
    .out_valid (lx_v),
    .coord     (lx)
  );

  spg_scale u_scale_z (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_v),
    .radius    (r_radius),
    .unit      (r_s),
    .out_valid (lz_v),
    .coord     (lz)
  );

  assign l_take = en & lx_v & lz_v;

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      s_v       <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (s_v) begin
        out_valid <= 1'b1;
        s_v       <= 1'b0;
      end else begin
        out_valid <= l_take;
      end
    end else if (l_take) begin
      s_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (s_v) begin
        coord_x <= s_x;
        coord_z <= s_z;
      end else begin
        coord_x <= lx;
        coord_z <= lz;
      end
    end else if (l_take) begin
      s_x <= lx;
      s_z <= lz;
    end
  end

endmodule
